/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk with synchronous reset rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at this edge implies consequent at the same edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tdp_pkg.sv */
// ---------------------------------------------------------------------------
// tdp_pkg
// Shared types and constants for the two-dimensional parity checker.
// ---------------------------------------------------------------------------
package tdp_pkg;

  localparam int MAX_SIZE_DEF = 128;
  localparam logic [7:0] SIZE_RESET = 8'd4;
  localparam int GROUP_W = 8;   // columns per summary group in the back end

  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_FIX     = 2'd1,
    VERDICT_CORRUPT = 2'd2
  } verdict_t;

  // Row side of a finished matrix: odd row count (saturating at 2) and the
  // 1-based location of the first odd row, already truncated to 8 bits.
  typedef struct packed {
    logic [1:0] odd_rows;
    logic [7:0] fix_row;
  } row_sum_t;

  localparam int ROW_SUM_W = $bits(row_sum_t);

endpackage

/* rtl/core/tdp_front.sv */
// ---------------------------------------------------------------------------
// tdp_front
// Takes matrix bits, tracks row/column parity and positions, and emits one
// record per finished matrix: row summary plus masked column parity vector.
// ---------------------------------------------------------------------------
module tdp_front #(
  parameter int MAX_SIZE = tdp_pkg::MAX_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            matrix_size,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_bit_value,
  input  logic                  push_ok,
  output logic                  push,
  output tdp_pkg::row_sum_t     push_rows,
  output logic [MAX_SIZE-1:0]   push_cols
);

  localparam int PW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam logic [8:0] MAX_V = 9'(MAX_SIZE);

  logic [PW-1:0]       col_pos_r, col_pos_nxt;
  logic [PW-1:0]       row_pos_r, row_pos_nxt;
  logic                row_par_r, row_par_nxt;
  logic [1:0]          odd_rows_r, odd_rows_nxt;
  logic [PW-1:0]       first_row_r, first_row_nxt;
  logic [MAX_SIZE-1:0] col_par_r, col_par_nxt;

  logic [8:0]          size_eff;
  logic                accept, row_end, mat_end, row_par_now;
  logic [MAX_SIZE-1:0] col_par_upd, col_mask;
  logic [1:0]          odd_rows_upd;
  logic [PW-1:0]       first_row_upd;
  logic [8:0]          fix_row9;

  assign in_ready = push_ok;
  assign accept   = in_valid & in_ready;

  // Zero counts as one; anything above the storage depth is clamped.
  always_comb begin
    if (matrix_size == 8'd0) begin
      size_eff = 9'd1;
    end else if ({1'b0, matrix_size} > MAX_V) begin
      size_eff = MAX_V;
    end else begin
      size_eff = {1'b0, matrix_size};
    end
  end

  assign row_end     = (9'(col_pos_r) + 9'd1) >= size_eff;
  assign mat_end     = row_end && ((9'(row_pos_r) + 9'd1) >= size_eff);
  assign row_par_now = row_par_r ^ in_bit_value;

  always_comb begin
    col_par_upd = col_par_r;
    col_par_upd[col_pos_r] = col_par_r[col_pos_r] ^ in_bit_value;
  end

  always_comb begin
    for (int c = 0; c < MAX_SIZE; c++) begin
      col_mask[c] = 9'(c) < size_eff;
    end
  end

  always_comb begin
    odd_rows_upd  = odd_rows_r;
    first_row_upd = first_row_r;
    if (row_end && row_par_now) begin
      if (odd_rows_r == 2'd0) begin
        first_row_upd = row_pos_r;
      end
      if (odd_rows_r != 2'd2) begin
        odd_rows_upd = odd_rows_r + 2'd1;
      end
    end
  end

  assign fix_row9  = 9'(first_row_upd) + 9'd1;
  assign push      = accept && mat_end;
  assign push_rows = '{odd_rows: odd_rows_upd, fix_row: fix_row9[7:0]};
  assign push_cols = col_par_upd & col_mask;

  always_comb begin
    col_pos_nxt   = col_pos_r;
    row_pos_nxt   = row_pos_r;
    row_par_nxt   = row_par_r;
    odd_rows_nxt  = odd_rows_r;
    first_row_nxt = first_row_r;
    col_par_nxt   = col_par_r;
    if (accept) begin
      if (mat_end) begin
        col_pos_nxt   = '0;
        row_pos_nxt   = '0;
        row_par_nxt   = 1'b0;
        odd_rows_nxt  = 2'd0;
        first_row_nxt = '0;
        col_par_nxt   = '0;
      end else if (row_end) begin
        col_pos_nxt   = '0;
        row_pos_nxt   = row_pos_r + PW'(1);
        row_par_nxt   = 1'b0;
        odd_rows_nxt  = odd_rows_upd;
        first_row_nxt = first_row_upd;
        col_par_nxt   = col_par_upd;
      end else begin
        col_pos_nxt   = col_pos_r + PW'(1);
        row_par_nxt   = row_par_now;
        col_par_nxt   = col_par_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r   <= '0;
      row_pos_r   <= '0;
      row_par_r   <= 1'b0;
      odd_rows_r  <= 2'd0;
      first_row_r <= '0;
      col_par_r   <= '0;
    end else begin
      col_pos_r   <= col_pos_nxt;
      row_pos_r   <= row_pos_nxt;
      row_par_r   <= row_par_nxt;
      odd_rows_r  <= odd_rows_nxt;
      first_row_r <= first_row_nxt;
      col_par_r   <= col_par_nxt;
    end
  end

endmodule

/* rtl/core/tdp_fifo.sv */
// ---------------------------------------------------------------------------
// tdp_fifo
// Two-entry queue of finished-matrix records between front and back end.
// ---------------------------------------------------------------------------
module tdp_fifo #(
  parameter int WIDTH = tdp_pkg::ROW_SUM_W + tdp_pkg::MAX_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full       = count_r == 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/core/tdp_back.sv */
// ---------------------------------------------------------------------------
// tdp_back
// Counts odd columns of a finished matrix through a two-level registered
// tree (8-column groups, then across groups) and forms the verdict.
// ---------------------------------------------------------------------------
module tdp_back #(
  parameter int MAX_SIZE = tdp_pkg::MAX_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  tdp_pkg::row_sum_t   head_rows,
  input  logic [MAX_SIZE-1:0] head_cols,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_verdict,
  output logic [7:0]          out_fix_row,
  output logic [7:0]          out_fix_col
);

  localparam int GW = tdp_pkg::GROUP_W;
  localparam int NG = (MAX_SIZE + GW - 1) / GW;

  // group summary stage
  logic              a_valid_r, a_valid_nxt;
  tdp_pkg::row_sum_t a_rows_r;
  logic              grp_nz_r    [NG];
  logic              grp_multi_r [NG];
  logic [2:0]        grp_idx_r   [NG];
  logic              grp_nz      [NG];
  logic              grp_multi   [NG];
  logic [2:0]        grp_idx     [NG];
  logic [NG*GW-1:0]  cols_pad;

  // output register
  logic              out_valid_r, out_valid_nxt;
  tdp_pkg::verdict_t out_verdict_r, verdict_nxt;
  logic [7:0]        out_fix_row_r, fix_row_nxt;
  logic [7:0]        out_fix_col_r, fix_col_nxt;

  logic              out_load, a_ready;
  logic [1:0]        odd_cols;
  logic [8:0]        first_col9, fix_col9;

  assign out_load = a_valid_r && (!out_valid_r || out_ready);
  assign a_ready  = !a_valid_r || out_load;
  assign pop      = head_valid && a_ready;

  assign cols_pad = (NG*GW)'(head_cols);

  // Index is only used when exactly one bit is set, so an OR of the
  // set bits' positions gives it without a priority chain.
  always_comb begin
    logic       seen, two;
    logic [2:0] ix;
    for (int g = 0; g < NG; g++) begin
      seen = 1'b0;
      two  = 1'b0;
      ix   = 3'd0;
      for (int i = 0; i < GW; i++) begin
        two  = two | (seen & cols_pad[g*GW+i]);
        seen = seen | cols_pad[g*GW+i];
        ix   = ix | (cols_pad[g*GW+i] ? 3'(i) : 3'd0);
      end
      grp_nz[g]    = seen;
      grp_multi[g] = two;
      grp_idx[g]   = ix;
    end
  end

  always_comb begin
    logic seen, two;
    seen       = 1'b0;
    two        = 1'b0;
    first_col9 = 9'd0;
    for (int g = 0; g < NG; g++) begin
      two        = two | grp_multi_r[g] | (seen & grp_nz_r[g]);
      seen       = seen | grp_nz_r[g];
      first_col9 = first_col9 |
                   (grp_nz_r[g] ? (9'(g*GW) + 9'(grp_idx_r[g])) : 9'd0);
    end
    if (!seen) begin
      odd_cols = 2'd0;
    end else if (two) begin
      odd_cols = 2'd2;
    end else begin
      odd_cols = 2'd1;
    end
  end

  assign fix_col9 = first_col9 + 9'd1;

  always_comb begin
    if (a_rows_r.odd_rows == 2'd0 && odd_cols == 2'd0) begin
      verdict_nxt = tdp_pkg::VERDICT_OK;
      fix_row_nxt = 8'd0;
      fix_col_nxt = 8'd0;
    end else if (a_rows_r.odd_rows == 2'd1 && odd_cols == 2'd1) begin
      verdict_nxt = tdp_pkg::VERDICT_FIX;
      fix_row_nxt = a_rows_r.fix_row;
      fix_col_nxt = fix_col9[7:0];
    end else begin
      verdict_nxt = tdp_pkg::VERDICT_CORRUPT;
      fix_row_nxt = 8'd0;
      fix_col_nxt = 8'd0;
    end
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (a_ready) begin
      a_valid_nxt = head_valid;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_rows_r <= head_rows;
      for (int g = 0; g < NG; g++) begin
        grp_nz_r[g]    <= grp_nz[g];
        grp_multi_r[g] <= grp_multi[g];
        grp_idx_r[g]   <= grp_idx[g];
      end
    end
    if (out_load) begin
      out_verdict_r <= verdict_nxt;
      out_fix_row_r <= fix_row_nxt;
      out_fix_col_r <= fix_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;
  assign out_fix_row = out_fix_row_r;
  assign out_fix_col = out_fix_col_r;

endmodule

/* rtl/core/two_d_parity_checker.sv */
// ---------------------------------------------------------------------------
// two_d_parity_checker
// Two-dimensional parity check of a square bit matrix with single-bit
// error location.
// ---------------------------------------------------------------------------
// channel  dir  handshake             payload
// in       in   in_valid/in_ready     in_bit_value (1b, row-major)
// out      out  out_valid/out_ready   out_verdict (2b), out_fix_row, out_fix_col (8b)
// cfg      in   cfg_valid/cfg_ready   cfg_matrix_size (8b), always ready
//
// One bit per cycle while the record queue is not full; only the last bit of a
// matrix yields an item. That item passes through the record queue, the group
// stage and the output register before it shows up.
// Reset sets the side length to 4 and clears all parity state; no sweep.
// in_ready drops only when the two-entry record queue is full.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module two_d_parity_checker #(
  parameter int MAX_SIZE = tdp_pkg::MAX_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_matrix_size,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_bit_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_verdict,
  output logic [7:0] out_fix_row,
  output logic [7:0] out_fix_col
);

  localparam int QW = tdp_pkg::ROW_SUM_W + MAX_SIZE;

  logic [7:0]          size_r, size_nxt;
  logic                fifo_push, fifo_full, fifo_pop, fifo_valid;
  tdp_pkg::row_sum_t   push_rows, head_rows;
  logic [MAX_SIZE-1:0] push_cols, head_cols;
  logic [QW-1:0]       head_data;

  assign cfg_ready = 1'b1;
  assign size_nxt  = (cfg_valid && cfg_ready) ? cfg_matrix_size : size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= tdp_pkg::SIZE_RESET;
    end else begin
      size_r <= size_nxt;
    end
  end

  tdp_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .matrix_size  (size_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_bit_value (in_bit_value),
    .push_ok      (!fifo_full),
    .push         (fifo_push),
    .push_rows    (push_rows),
    .push_cols    (push_cols)
  );

  tdp_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fifo_push),
    .push_data  ({push_rows, push_cols}),
    .full       (fifo_full),
    .pop        (fifo_pop),
    .head_valid (fifo_valid),
    .head_data  (head_data)
  );

  assign head_rows = head_data[QW-1 -: tdp_pkg::ROW_SUM_W];
  assign head_cols = head_data[MAX_SIZE-1:0];

  tdp_back #(
    .MAX_SIZE (MAX_SIZE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (fifo_valid),
    .head_rows   (head_rows),
    .head_cols   (head_cols),
    .pop         (fifo_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_verdict (out_verdict),
    .out_fix_row (out_fix_row),
    .out_fix_col (out_fix_col)
  );

  `ASSERT_IMPL(a_no_overflow, fifo_push, !fifo_full || fifo_pop, "record queue overflow")
  `ASSERT_IMPL(a_pop_nonempty, fifo_pop, fifo_valid, "pop from empty record queue")
  `ASSERT_CLK(a_fix_zero, !out_valid || out_verdict == tdp_pkg::VERDICT_FIX || (out_fix_row == 8'd0 && out_fix_col == 8'd0), "location set without a fix verdict")

endmodule

/* verif/two_d_parity_checker_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_d_parity_checker_tb
// Streams square bit matrices into the parity checker at a random pace and
// checks every verdict against an in-bench tracker of row and column parity.
// Side length changes between phases, some of them in the middle of a matrix.
// ---------------------------------------------------------------------------
module two_d_parity_checker_tb;

  localparam int MAXN = tdp_pkg::MAX_SIZE_DEF;

  typedef struct {
    tdp_pkg::verdict_t verdict;
    logic [7:0]        fix_row;
    logic [7:0]        fix_col;
  } verdict_item_t;

  typedef enum int {
    MAT_CLEAN,
    MAT_ONE_FLIP,
    MAT_MULTI_FLIP,
    MAT_NOISE
  } matrix_kind_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_matrix_size = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_bit_value = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_verdict;
  logic [7:0] out_fix_row;
  logic [7:0] out_fix_col;

  two_d_parity_checker u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_matrix_size(cfg_matrix_size),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_bit_value   (in_bit_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_verdict    (out_verdict),
    .out_fix_row    (out_fix_row),
    .out_fix_col    (out_fix_col)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // parity tracker state
  logic [7:0]  size_reg;
  bit          col_par [MAXN];
  bit          row_par;
  int unsigned row_pos;
  int unsigned col_pos;
  int unsigned odd_rows;
  int unsigned first_row;

  verdict_item_t verdict_q[$];
  bit            bits_q[$];
  int unsigned   pending_bits = 0;
  int unsigned   pushed_bits = 0;
  int unsigned   mismatches = 0;
  int unsigned   in_hold = 0;
  int unsigned   out_hold = 0;
  bit            no_idle = 1'b0;

  function automatic int unsigned eff_size(logic [7:0] v);
    if (v == 8'd0) return 1;
    if (v > MAXN) return MAXN;
    return v;
  endfunction

  function automatic void clear_parity();
    foreach (col_par[i]) col_par[i] = 1'b0;
    row_par = 1'b0;
    row_pos = 0;
    col_pos = 0;
    odd_rows = 0;
    first_row = 0;
  endfunction

  function automatic void track_bit(bit b);
    int unsigned   s;
    int unsigned   odd_cols;
    int unsigned   first_col;
    verdict_item_t v;
    s = eff_size(size_reg);
    row_par ^= b;
    col_par[col_pos % MAXN] ^= b;
    if (col_pos + 1 < s) begin
      col_pos++;
      return;
    end
    // row done; position may already be past the last column after a resize
    if (row_par) begin
      if (odd_rows == 0) first_row = row_pos;
      if (odd_rows < 2) odd_rows++;
    end
    row_par = 1'b0;
    col_pos = 0;
    if (row_pos + 1 < s) begin
      row_pos++;
      return;
    end
    odd_cols = 0;
    first_col = 0;
    for (int unsigned c = 0; c < s; c++) begin
      if (col_par[c]) begin
        if (odd_cols == 0) first_col = c;
        if (odd_cols < 2) odd_cols++;
      end
    end
    if (odd_rows == 0 && odd_cols == 0) begin
      v = '{tdp_pkg::VERDICT_OK, 8'd0, 8'd0};
    end else if (odd_rows == 1 && odd_cols == 1) begin
      v = '{tdp_pkg::VERDICT_FIX, 8'(first_row + 1), 8'(first_col + 1)};
    end else begin
      v = '{tdp_pkg::VERDICT_CORRUPT, 8'd0, 8'd0};
    end
    verdict_q.push_back(v);
    clear_parity();
  endfunction

  // mostly short gaps, a few long ones, none at all in burst phases
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic void report(string what, int unsigned exp_val, int unsigned act_val);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_val, act_val);
  endfunction

  // driver: input bits and tracker updates on accepted items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_bit_value <= 1'b0;
      size_reg = tdp_pkg::SIZE_RESET;
      clear_parity();
    end else begin
      if (cfg_valid && cfg_ready) size_reg = cfg_matrix_size;
      if (in_valid && in_ready) begin
        track_bit(in_bit_value);
        pending_bits--;
      end
      if (!in_valid || in_ready) begin
        if (in_hold > 0) begin
          in_hold--;
          in_valid <= 1'b0;
        end else if (bits_q.size() > 0) begin
          in_valid <= 1'b1;
          in_bit_value <= bits_q.pop_front();
          in_hold = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result side with random stalls
  always @(posedge clk) begin : monitor
    verdict_item_t exp_v;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item, expected none actual verdict=%0d row=%0d col=%0d",
                   $time, out_verdict, out_fix_row, out_fix_col);
        end else begin
          exp_v = verdict_q.pop_front();
          if (out_verdict !== exp_v.verdict) report("verdict", exp_v.verdict, out_verdict);
          if (out_fix_row !== exp_v.fix_row) report("fix_row", exp_v.fix_row, out_fix_row);
          if (out_fix_col !== exp_v.fix_col) report("fix_col", exp_v.fix_col, out_fix_col);
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_hold = pick_gap();
      end
    end
  end

  function automatic void push_bit(bit b);
    bits_q.push_back(b);
    pending_bits++;
    pushed_bits++;
  endfunction

  // wait until every bit is taken and every verdict seen, then let the pipe drain
  task automatic settle();
    while (pending_bits != 0 || verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_size(logic [7:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_matrix_size <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // even-parity matrix with random content, then damaged per kind
  task automatic add_matrix(int unsigned n, matrix_kind_t kind);
    bit          m [MAXN][MAXN];
    bit          acc;
    int unsigned flips;
    for (int unsigned r = 0; r + 1 < n; r++)
      for (int unsigned c = 0; c + 1 < n; c++)
        m[r][c] = $urandom_range(0, 1);
    for (int unsigned r = 0; r + 1 < n; r++) begin
      acc = 1'b0;
      for (int unsigned c = 0; c + 1 < n; c++) acc ^= m[r][c];
      m[r][n-1] = acc;
    end
    for (int unsigned c = 0; c < n; c++) begin
      acc = 1'b0;
      for (int unsigned r = 0; r + 1 < n; r++) acc ^= m[r][c];
      m[n-1][c] = acc;
    end
    case (kind)
      MAT_ONE_FLIP:   flips = 1;
      MAT_MULTI_FLIP: flips = $urandom_range(2, 4);
      default:        flips = 0;
    endcase
    repeat (flips) m[$urandom_range(0, n - 1)][$urandom_range(0, n - 1)] ^= 1'b1;
    for (int unsigned r = 0; r < n; r++)
      for (int unsigned c = 0; c < n; c++)
        push_bit(kind == MAT_NOISE ? bit'($urandom_range(0, 1)) : m[r][c]);
  endtask

  function automatic matrix_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return MAT_CLEAN;
    if (r < 7) return MAT_ONE_FLIP;
    if (r < 9) return MAT_MULTI_FLIP;
    return MAT_NOISE;
  endfunction

  initial begin
    logic [7:0]  sz;
    int unsigned n;
    int unsigned start_bits;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset size: single error in the bottom right corner
    for (int i = 0; i < 16; i++) push_bit(i == 15);
    // size 1: one set bit is a fixable error, a clear one is fine
    write_size(8'd1);
    push_bit(1'b1);
    push_bit(1'b0);
    // size 0 acts as 1
    write_size(8'd0);
    push_bit(1'b1);
    // size 2: two odd columns only, then two odd rows only
    write_size(8'd2);
    push_bit(1'b1); push_bit(1'b1); push_bit(1'b0); push_bit(1'b0);
    push_bit(1'b1); push_bit(1'b0); push_bit(1'b1); push_bit(1'b0);
    // shrink mid-matrix with the column position already past the new size
    write_size(8'd4);
    push_bit(1'b1); push_bit(1'b0); push_bit(1'b1);
    write_size(8'd2);
    push_bit(1'b1); push_bit(1'b0); push_bit(1'b0);

    start_bits = pushed_bits;
    while (pushed_bits - start_bits < 780) begin
      case ($urandom_range(0, 19))
        0:       sz = 8'd0;
        1:       sz = 8'($urandom_range(9, 16));
        default: sz = 8'($urandom_range(1, 8));
      endcase
      write_size(sz);
      no_idle = ($urandom_range(0, 4) == 0);
      n = eff_size(sz);
      repeat ($urandom_range(1, 4)) add_matrix(n, pick_kind());
      // sometimes leave a matrix unfinished so the next size lands mid-matrix
      if (n > 1 && $urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, n * n - 1)) push_bit(bit'($urandom_range(0, 1)));
    end

    // oversize side length is clamped; a shrink then finishes the matrix
    no_idle = 1'b0;
    write_size(8'd255);
    repeat (5) push_bit(bit'($urandom_range(0, 1)));
    write_size(8'd3);
    repeat (7) push_bit(bit'($urandom_range(0, 1)));

    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
